// ----- rtl/core/assert_macros.svh -----
// assertion helpers shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/core/alm_pkg.sv -----
// ----------------------------------------------------------------------------
// alm_pkg
// Shared types and constants for the array linked list manager: field
// widths, status codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package alm_pkg;

	// field widths of request and response words
	localparam int POS_W     = 6;
	localparam int DATA_W    = 32;
	localparam int SLOT_W    = 5;
	localparam int STATUS_W  = 2;
	localparam int DEF_NODES = 32;

	// response status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_NO_POS  = 2'd1,
		ST_FULL    = 2'd2,
		ST_NOTHING = 2'd3
	} status_t;

	// controller states
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CHASE,
		S_WRITE1,
		S_WRITE2,
		S_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic    clear;
		logic    accept;
		logic    chase;
		logic    wr1;
		logic    wr2;
		logic    load_out;
		logic    status_wr;
		status_t status_code;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic pos_ok;
		logic req_delete;
		logic head_none;
		logic chase_none;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/array_linked_list_manager.sv -----
// ----------------------------------------------------------------------------
// array_linked_list_manager
// Linked list of NODES nodes held in value and link memories, with unused
// nodes chained on a free list. Each request word inserts or deletes after
// a given node and yields one response word.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | fields
//  --------+-----------+-----------------------+------------------------------
//  req     | in        | req_valid / req_ready | kind, position, value
//  rsp     | out       | rsp_valid / rsp_ready | status, slot, removed_value
//
//  every request takes a registered link read, a chase read for delete, then
//  two link writes on the single write port of the link memory, then the
//  response register load; a bad position or full store skips to the load, as
//  does a delete with nothing after its position once its chase read is done.
//  after reset a clearing sweep over all NODES nodes rebuilds the free list and
//  zeroes the values; req_ready stays low during it.
//  a response waiting on rsp_ready holds the block only at its hand-off step.
// ----------------------------------------------------------------------------
`default_nettype none

module array_linked_list_manager #(
	parameter int NODES = alm_pkg::DEF_NODES
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                req_valid,
	output logic                                     req_ready,
	input  wire logic                                kind,
	input  wire logic signed [alm_pkg::POS_W-1:0]    position,
	input  wire logic signed [alm_pkg::DATA_W-1:0]   value,
	output logic                                     rsp_valid,
	input  wire logic                                rsp_ready,
	output logic             [alm_pkg::STATUS_W-1:0] status,
	output logic             [alm_pkg::SLOT_W-1:0]   slot,
	output logic signed      [alm_pkg::DATA_W-1:0]   removed_value
);
	import alm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer
	alm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// memories and registers
	alm_data #(
		.NODES (NODES)
	) u_data (
		.clk           (clk),
		.arst_n        (arst_n),
		.kind          (kind),
		.position      (position),
		.value         (value),
		.rsp_valid     (rsp_valid),
		.rsp_ready     (rsp_ready),
		.status        (status),
		.slot          (slot),
		.removed_value (removed_value),
		.cmd           (cmd),
		.sts           (sts)
	);

endmodule

`default_nettype wire

// ----- rtl/core/alm_ctrl.sv -----
// ----------------------------------------------------------------------------
// alm_ctrl
// Sequencer for the list manager: clearing sweep after reset, then one
// request word at a time through read, link chase, two link writes and
// the response hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module alm_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         req_valid,
	output logic              req_ready,
	input  wire alm_pkg::sts_t sts,
	output alm_pkg::cmd_t     cmd
);
	import alm_pkg::*;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d         = state_q;
		cmd             = '0;
		cmd.status_code = ST_OK;
		req_ready       = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.accept    = 1'b1;
					cmd.status_wr = 1'b1;
					if (!sts.pos_ok) begin
						cmd.status_code = ST_NO_POS;
						state_d         = S_EMIT;
					end else if (sts.req_delete) begin
						state_d = S_CHASE;
					end else if (sts.head_none) begin
						cmd.status_code = ST_FULL;
						state_d         = S_EMIT;
					end else begin
						state_d = S_WRITE1;
					end
				end
			end
			S_CHASE: begin
				cmd.chase = 1'b1;
				if (sts.chase_none) begin
					cmd.status_wr   = 1'b1;
					cmd.status_code = ST_NOTHING;
					state_d         = S_EMIT;
				end else begin
					state_d = S_WRITE1;
				end
			end
			S_WRITE1: begin
				cmd.wr1 = 1'b1;
				state_d = S_WRITE2;
			end
			S_WRITE2: begin
				cmd.wr2 = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/core/alm_data.sv -----
// ----------------------------------------------------------------------------
// alm_data
// Datapath for the list manager: node value and link memories, free-list
// head, request capture, clearing counter and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module alm_data #(
	parameter int NODES = alm_pkg::DEF_NODES
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                kind,
	input  wire logic signed [alm_pkg::POS_W-1:0]    position,
	input  wire logic signed [alm_pkg::DATA_W-1:0]   value,
	output logic                                     rsp_valid,
	input  wire logic                                rsp_ready,
	output logic             [alm_pkg::STATUS_W-1:0] status,
	output logic             [alm_pkg::SLOT_W-1:0]   slot,
	output logic signed      [alm_pkg::DATA_W-1:0]   removed_value,
	input  wire alm_pkg::cmd_t                       cmd,
	output alm_pkg::sts_t                            sts
);
	import alm_pkg::*;

	localparam int IW = $clog2(NODES);
	localparam int LW = IW + 1;
	localparam logic [LW-1:0] LINK_NONE = LW'(NODES);
	localparam logic [IW-1:0] LAST_IDX  = IW'(NODES - 1);

	// node stores
	logic [LW-1:0]     link_mem [NODES];
	logic [DATA_W-1:0] val_mem  [NODES];

	// request and working registers
	logic [IW-1:0]     p_q;
	logic [IW-1:0]     q_q;
	logic [DATA_W-1:0] value_q;
	logic              is_del_q;
	status_t           status_q;
	logic [LW-1:0]     free_head_q;
	logic [IW-1:0]     clr_q;
	logic [LW-1:0]     rd_a_q;
	logic [LW-1:0]     rd_b_q;
	logic [DATA_W-1:0] rd_val_q;

	// response register
	logic              rsp_valid_q;
	logic [STATUS_W-1:0] rsp_status_q;
	logic [SLOT_W-1:0] rsp_slot_q;
	logic [DATA_W-1:0] rsp_removed_q;

	logic [IW-1:0]     p_in;
	logic              pos_ok;
	logic              lw_en;
	logic [IW-1:0]     lw_addr;
	logic [LW-1:0]     lw_data;
	logic              vw_en;
	logic [IW-1:0]     vw_addr;
	logic [DATA_W-1:0] vw_data;
	logic [IW-1:0]     rb_addr;
	logic              rb_en;

	// position decode: sign bit or index past the store means none
	assign pos_ok = !position[POS_W-1] && (32'(position[POS_W-2:0]) < NODES);
	assign p_in   = IW'(position[POS_W-2:0]);

	// status towards the controller
	always_comb begin
		sts            = '0;
		sts.clr_last   = (clr_q == LAST_IDX);
		sts.pos_ok     = pos_ok;
		sts.req_delete = kind;
		sts.head_none  = (free_head_q >= LINK_NONE);
		sts.chase_none = (rd_a_q >= LINK_NONE);
		sts.out_free   = !rsp_valid_q || rsp_ready;
	end

	// link write port: clearing sweep, then the two splice writes
	always_comb begin
		lw_en   = 1'b0;
		lw_addr = clr_q;
		lw_data = LW'(clr_q) + LW'(1);
		if (cmd.clear) begin
			lw_en = 1'b1;
		end else if (cmd.wr1) begin
			lw_en = 1'b1;
			if (is_del_q) begin
				lw_addr = p_q;
				lw_data = rd_b_q;
			end else begin
				lw_addr = q_q;
				lw_data = rd_a_q;
			end
		end else if (cmd.wr2) begin
			lw_en = 1'b1;
			if (is_del_q) begin
				lw_addr = q_q;
				lw_data = free_head_q;
			end else begin
				lw_addr = p_q;
				lw_data = LW'(q_q);
			end
		end
	end

	// value write port: clearing sweep or insert
	always_comb begin
		vw_en   = 1'b0;
		vw_addr = clr_q;
		vw_data = '0;
		if (cmd.clear) begin
			vw_en = 1'b1;
		end else if (cmd.wr1 && !is_del_q) begin
			vw_en   = 1'b1;
			vw_addr = q_q;
			vw_data = value_q;
		end
	end

	// second link read port follows the chase once the successor is known
	assign rb_en   = cmd.accept || cmd.chase;
	assign rb_addr = cmd.chase ? IW'(rd_a_q) : IW'(free_head_q);

	// link memory with registered reads
	always_ff @(posedge clk) begin
		if (lw_en) begin
			link_mem[lw_addr] <= lw_data;
		end
		if (cmd.accept) begin
			rd_a_q <= link_mem[p_in];
		end
		if (rb_en) begin
			rd_b_q <= link_mem[rb_addr];
		end
	end

	// value memory with registered read
	always_ff @(posedge clk) begin
		if (vw_en) begin
			val_mem[vw_addr] <= vw_data;
		end
		if (cmd.chase) begin
			rd_val_q <= val_mem[IW'(rd_a_q)];
		end
	end

	// request capture and node under work
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			p_q      <= p_in;
			q_q      <= IW'(free_head_q);
			value_q  <= value;
			is_del_q <= kind;
		end else if (cmd.chase) begin
			q_q <= IW'(rd_a_q);
		end
		if (cmd.status_wr) begin
			status_q <= cmd.status_code;
		end
	end

	// free-list head and clearing counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
			clr_q       <= '0;
		end else begin
			if (cmd.wr1 && !is_del_q) begin
				free_head_q <= rd_b_q;
			end else if (cmd.wr2 && is_del_q) begin
				free_head_q <= LW'(q_q);
			end
			if (cmd.clear && (clr_q != LAST_IDX)) begin
				clr_q <= clr_q + IW'(1);
			end
		end
	end

	// response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// response word, zero slot and data unless the operation went through
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			rsp_status_q  <= status_q;
			rsp_slot_q    <= (status_q == ST_OK) ? SLOT_W'(q_q) : '0;
			rsp_removed_q <= ((status_q == ST_OK) && is_del_q) ? rd_val_q : '0;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign status        = rsp_status_q;
	assign slot          = rsp_slot_q;
	assign removed_value = rsp_removed_q;

endmodule

`default_nettype wire

// ----- rtl/core/alm_checker.sv -----
// ----------------------------------------------------------------------------
// alm_checker
// Port-level checks for the list manager: response hold under stall,
// zeroed words on refusal, one request at a time and slot range.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module alm_checker #(
	parameter int NODES = alm_pkg::DEF_NODES
) (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                req_valid,
	input wire logic                                req_ready,
	input wire logic                                kind,
	input wire logic signed [alm_pkg::POS_W-1:0]    position,
	input wire logic signed [alm_pkg::DATA_W-1:0]   value,
	input wire logic                                rsp_valid,
	input wire logic                                rsp_ready,
	input wire logic             [alm_pkg::STATUS_W-1:0] status,
	input wire logic             [alm_pkg::SLOT_W-1:0]   slot,
	input wire logic signed      [alm_pkg::DATA_W-1:0]   removed_value
);
	import alm_pkg::*;

	logic req_fire;
	logic rsp_ok;
	logic unused_bits;

	assign req_fire    = req_valid && req_ready;
	assign rsp_ok      = rsp_valid && (status == ST_OK);
	assign unused_bits = kind ^ position[0] ^ value[0];

	// a stalled response word holds
	`ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(slot) && $stable(removed_value))

	// refused operations carry zero slot and data
	`ASSERT_IMP(a_refused_zero, clk, arst_n, rsp_valid && (status != ST_OK), (slot == '0) && (removed_value == '0) && !unused_bits || (slot == '0) && (removed_value == '0))

	// one request in flight: no request taken straight after another
	`ASSERT_NXT(a_one_at_a_time, clk, arst_n, req_fire, !req_ready)

	// an allocated or freed slot lies inside the store
	`ASSERT_IMP(a_slot_range, clk, arst_n, rsp_ok, (32'(slot) < NODES) || (NODES > (1 << SLOT_W)))

endmodule

bind array_linked_list_manager alm_checker #(.NODES(NODES)) u_alm_checker (.*);

`default_nettype wire
